[src/rmq_pkg.sv]
// Shared types and constants for the rotation matrix to quaternion converter.
// No dependencies.
package rmq_pkg;

  // Width of every matrix entry and quaternion component.
  localparam int unsigned DataW = 16;

  // Path codes reported in branch_taken.
  localparam logic [1:0] BrTrace = 2'd0;
  localparam logic [1:0] BrDiagX = 2'd1;
  localparam logic [1:0] BrDiagY = 2'd2;
  localparam logic [1:0] BrDiagZ = 2'd3;

  typedef struct packed {
    logic signed [DataW-1:0] m00;
    logic signed [DataW-1:0] m01;
    logic signed [DataW-1:0] m02;
    logic signed [DataW-1:0] m10;
    logic signed [DataW-1:0] m11;
    logic signed [DataW-1:0] m12;
    logic signed [DataW-1:0] m20;
    logic signed [DataW-1:0] m21;
    logic signed [DataW-1:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [DataW-1:0] quat_w;
    logic signed [DataW-1:0] quat_x;
    logic signed [DataW-1:0] quat_y;
    logic signed [DataW-1:0] quat_z;
    logic [1:0]              branch_taken;
    logic                    invalid_input;
  } out_t;

endpackage

[src/rotation_matrix_to_quaternion.sv]
// Rotation matrix to unit quaternion, trace method, fully pipelined.
// Depends on rmq_pkg (payload structs, path codes).
//
//  channel | signals                    | beat
//  --------+----------------------------+-------------------------------
//  input   | valid_i, ready_o, data_i   | nine matrix entries (in_t)
//  output  | valid_o, ready_i, data_o   | quaternion and flags (out_t)
//
// One beat per cycle while the output is not stalled. A beat passes through
// RW + NW + 4 register stages after it is accepted, most of them in the
// square-root pipeline (one root bit per stage, RW stages) and the
// long-division pipeline (one quotient bit per stage, NW = 16 + FRAC_BITS).
// Each stage holds a beat until the next stage frees up, so a stall on the
// output fills the empty stages first. Reset clears only the valid bits.
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  in_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output out_t data_o
);

  localparam int unsigned DW   = DataW;
  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned AW   = ((DW > FB) ? DW : FB + 1) + 2;  // root argument
  localparam int unsigned XW   = AW + FB - 2;                     // scaled argument
  localparam int unsigned RW   = (XW + 1) / 2;                    // floor root
  localparam int unsigned REMW = RW + 3;
  localparam int unsigned HW   = RW + 1;                          // rounded root
  localparam int unsigned NW   = DW + FB;                         // dividend
  localparam logic [NW-1:0] SatHi = NW'((64'd1 << (DW - 1)) - 64'd1);
  localparam logic [NW-1:0] SatLo = NW'(64'd1 << (DW - 1));

  // ---------------- square-root stages (index 0 = input register) --------
  logic                 sq_v_q   [RW+1];
  logic                 sq_en    [RW+1];
  logic [1:0]           sq_br_q  [RW+1];
  logic                 sq_inv_q [RW+1];
  logic [2*RW-1:0]      sq_x_q   [RW+1];
  logic [RW-1:0]        sq_r_q   [RW+1];
  logic [REMW-1:0]      sq_rem_q [RW+1];
  logic signed [DW:0]   sq_num_q [RW+1][4];

  // rounding stage
  logic                 rd_v_q, rd_en;
  logic [1:0]           rd_br_q;
  logic                 rd_inv_q;
  logic [HW-1:0]        rd_h_q;
  logic signed [DW:0]   rd_num_q [4];

  // ---------------- division stages (index 0 = dividend prep) -----------
  logic                 dv_v_q   [NW+1];
  logic                 dv_en    [NW+1];
  logic [1:0]           dv_br_q  [NW+1];
  logic                 dv_inv_q [NW+1];
  logic [HW-1:0]        dv_h_q   [NW+1];
  logic [3:0]           dv_neg_q [NW+1];
  logic [NW-1:0]        dv_n_q   [NW+1][4];
  logic [HW:0]          dv_rem_q [NW+1][4];

  // output register
  logic out_v_q, out_en;
  out_t out_q, out_d;

  // Stage enables: a stage loads when empty or when its successor loads.
  assign out_en = !out_v_q || ready_i;
  assign dv_en[NW] = !dv_v_q[NW] || out_en;
  for (genvar k = 0; k < NW; k++) begin : g_dv_en
    assign dv_en[k] = !dv_v_q[k] || dv_en[k+1];
  end
  assign rd_en = !rd_v_q || dv_en[0];
  assign sq_en[RW] = !sq_v_q[RW] || rd_en;
  for (genvar k = 0; k < RW; k++) begin : g_sq_en
    assign sq_en[k] = !sq_v_q[k] || sq_en[k+1];
  end
  assign ready_o = sq_en[0];

  // ---------------- input stage: trace, path pick, root argument --------
  logic signed [AW-1:0] e00, e11, e22, trace, arg, one;
  logic [1:0]           br_d;
  logic signed [DW:0]   num_d [4];

  always_comb begin
    e00   = AW'(data_i.m00);
    e11   = AW'(data_i.m11);
    e22   = AW'(data_i.m22);
    one   = AW'(64'd1 << FB);
    trace = e00 + e11 + e22;
    if (!trace[AW-1]) begin
      br_d = BrTrace;
      arg  = trace + one;
    end else if (e11 > e00) begin
      if (e22 > e11) begin
        br_d = BrDiagZ;
        arg  = e22 - (e00 + e11) + one;
      end else begin
        br_d = BrDiagY;
        arg  = e11 - (e22 + e00) + one;
      end
    end else if (e22 > e00) begin
      br_d = BrDiagZ;
      arg  = e22 - (e00 + e11) + one;
    end else begin
      br_d = BrDiagX;
      arg  = e00 - (e11 + e22) + one;
    end
  end

  // Off-diagonal terms per component, slots ordered w, x, y, z.
  always_comb begin
    num_d[0] = '0;
    num_d[1] = '0;
    num_d[2] = '0;
    num_d[3] = '0;
    unique case (br_d)
      BrTrace: begin
        num_d[1] = (DW+1)'(data_i.m21) - (DW+1)'(data_i.m12);
        num_d[2] = (DW+1)'(data_i.m02) - (DW+1)'(data_i.m20);
        num_d[3] = (DW+1)'(data_i.m10) - (DW+1)'(data_i.m01);
      end
      BrDiagX: begin
        num_d[2] = (DW+1)'(data_i.m10) + (DW+1)'(data_i.m01);
        num_d[3] = (DW+1)'(data_i.m02) + (DW+1)'(data_i.m20);
        num_d[0] = (DW+1)'(data_i.m21) - (DW+1)'(data_i.m12);
      end
      BrDiagY: begin
        num_d[3] = (DW+1)'(data_i.m21) + (DW+1)'(data_i.m12);
        num_d[1] = (DW+1)'(data_i.m10) + (DW+1)'(data_i.m01);
        num_d[0] = (DW+1)'(data_i.m02) - (DW+1)'(data_i.m20);
      end
      default: begin
        num_d[1] = (DW+1)'(data_i.m02) + (DW+1)'(data_i.m20);
        num_d[2] = (DW+1)'(data_i.m21) + (DW+1)'(data_i.m12);
        num_d[0] = (DW+1)'(data_i.m10) - (DW+1)'(data_i.m01);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_v_q[0] <= 1'b0;
    end else if (sq_en[0]) begin
      sq_v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_en[0]) begin
      sq_br_q[0]  <= br_d;
      sq_inv_q[0] <= (arg <= 0);
      sq_x_q[0]   <= (arg <= 0) ? '0 :
                     ((2*RW)'(unsigned'(arg)) << (FB - 2));
      sq_r_q[0]   <= '0;
      sq_rem_q[0] <= '0;
      for (int s = 0; s < 4; s++) sq_num_q[0][s] <= num_d[s];
    end
  end

  // ---------------- square root, one result bit per stage ---------------
  for (genvar k = 1; k <= RW; k++) begin : g_sqrt
    logic [REMW-1:0] rem_sh, trial;
    logic            ge;

    always_comb begin
      rem_sh = {sq_rem_q[k-1][REMW-3:0], sq_x_q[k-1][2*RW-1:2*RW-2]};
      trial  = {1'b0, sq_r_q[k-1], 2'b01};
      ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (sq_en[k]) begin
        sq_v_q[k] <= sq_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (sq_en[k]) begin
        sq_rem_q[k] <= ge ? (rem_sh - trial) : rem_sh;
        sq_r_q[k]   <= {sq_r_q[k-1][RW-2:0], ge};
        sq_x_q[k]   <= sq_x_q[k-1] << 2;
        sq_br_q[k]  <= sq_br_q[k-1];
        sq_inv_q[k] <= sq_inv_q[k-1];
        for (int s = 0; s < 4; s++) sq_num_q[k][s] <= sq_num_q[k-1][s];
      end
    end
  end

  // ---------------- round root to nearest --------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_v_q <= 1'b0;
    end else if (rd_en) begin
      rd_v_q <= sq_v_q[RW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_h_q   <= HW'(sq_r_q[RW]) +
                  HW'(sq_rem_q[RW] > REMW'(sq_r_q[RW]));
      rd_br_q  <= sq_br_q[RW];
      rd_inv_q <= sq_inv_q[RW];
      for (int s = 0; s < 4; s++) rd_num_q[s] <= sq_num_q[RW][s];
    end
  end

  // ---------------- dividend prep: |D| << (F-2) plus h/2 -----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else if (dv_en[0]) begin
      dv_v_q[0] <= rd_v_q;
    end
  end

  // magnitude taken one bit wider so the most negative term stays positive
  always_ff @(posedge clk_i) begin
    if (dv_en[0]) begin
      dv_h_q[0]   <= rd_h_q;
      dv_br_q[0]  <= rd_br_q;
      dv_inv_q[0] <= rd_inv_q;
      for (int s = 0; s < 4; s++) begin
        dv_neg_q[0][s] <= rd_num_q[s][DW];
        dv_n_q[0][s]   <= ((NW'(rd_num_q[s][DW] ? -((DW+2)'(rd_num_q[s]))
                                                : (DW+2)'(rd_num_q[s])))
                           << (FB - 2)) + NW'(rd_h_q >> 1);
        dv_rem_q[0][s] <= '0;
      end
    end
  end

  // ---------------- long division, one quotient bit per stage ------------
  for (genvar k = 1; k <= NW; k++) begin : g_div
    logic [HW:0] rem_sh [4];
    logic [3:0]  ge;

    always_comb begin
      for (int s = 0; s < 4; s++) begin
        rem_sh[s] = {dv_rem_q[k-1][s][HW-1:0], dv_n_q[k-1][s][NW-1]};
        ge[s]     = (rem_sh[s] >= {1'b0, dv_h_q[k-1]});
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[k] <= 1'b0;
      end else if (dv_en[k]) begin
        dv_v_q[k] <= dv_v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (dv_en[k]) begin
        dv_h_q[k]   <= dv_h_q[k-1];
        dv_br_q[k]  <= dv_br_q[k-1];
        dv_inv_q[k] <= dv_inv_q[k-1];
        dv_neg_q[k] <= dv_neg_q[k-1];
        for (int s = 0; s < 4; s++) begin
          dv_rem_q[k][s] <= ge[s] ? (rem_sh[s] - {1'b0, dv_h_q[k-1]}) : rem_sh[s];
          dv_n_q[k][s]   <= {dv_n_q[k-1][s][NW-2:0], ge[s]};
        end
      end
    end
  end

  // ---------------- sign, saturate, pick the root slot -------------------
  logic [NW-1:0]        mag [4];
  logic signed [DW-1:0] comp [4];

  always_comb begin
    for (int s = 0; s < 4; s++) begin
      if (dv_br_q[NW] == 2'(s)) begin
        mag[s] = NW'(dv_h_q[NW]);
        comp[s] = (mag[s] > SatHi) ? DW'(SatHi) : DW'(mag[s]);
      end else begin
        mag[s] = dv_n_q[NW][s];
        if (dv_neg_q[NW][s]) begin
          comp[s] = (mag[s] > SatLo) ? DW'(SatLo) : DW'(-mag[s]);
        end else begin
          comp[s] = (mag[s] > SatHi) ? DW'(SatHi) : DW'(mag[s]);
        end
      end
      if (dv_inv_q[NW]) comp[s] = '0;
    end
    out_d.quat_w        = comp[0];
    out_d.quat_x        = comp[1];
    out_d.quat_y        = comp[2];
    out_d.quat_z        = comp[3];
    out_d.branch_taken  = dv_br_q[NW];
    out_d.invalid_input = dv_inv_q[NW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= dv_v_q[NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

[test/rotation_matrix_to_quaternion_checker.sv]
// Checker for the rotation matrix to quaternion converter: watches both
// channels, predicts each result from the accepted matrix and compares.
// Depends on rmq_pkg (in_t, out_t, path codes).
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_checker
  import rmq_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 14
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  logic ready_o,
  input  in_t  data_i,
  input  logic valid_o,
  input  logic ready_i,
  input  out_t data_o,
  output int   fail_count_o,
  output int   pending_o
);

  out_t quat_expected_q[$];

  // Rounded integer square root
  function automatic longint unsigned root_round(longint unsigned x);
    longint unsigned res, bitv, n;
    res = 0;
    bitv = 64'd1 << 62;
    n = x;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    if (n > res) res = res + 1;
    return res;
  endfunction

  // d * 2^(F-2) / h, nearest, ties away from zero
  function automatic longint div_half_root(longint d, longint unsigned h);
    longint unsigned mag, q;
    mag = (d < 0) ? longint'(-d) : d;
    q = ((mag << (FRAC_BITS - 2)) + (h >> 1)) / h;
    return (d < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [DataW-1:0] clamp(longint v);
    longint hi, lo;
    hi = (longint'(1) <<< (DataW - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi[DataW-1:0];
    if (v < lo) return lo[DataW-1:0];
    return v[DataW-1:0];
  endfunction

  function automatic out_t predict_quat(in_t m);
    out_t r;
    longint d00, d01, d02, d10, d11, d12, d20, d21, d22;
    longint one, tr, arg, qw, qx, qy, qz;
    longint unsigned h;
    logic [1:0] path;
    d00 = m.m00; d01 = m.m01; d02 = m.m02;
    d10 = m.m10; d11 = m.m11; d12 = m.m12;
    d20 = m.m20; d21 = m.m21; d22 = m.m22;
    one = longint'(1) <<< FRAC_BITS;
    tr = d00 + d11 + d22;
    path = BrTrace;
    if (tr >= 0) begin
      arg = tr + one;
    end else begin
      // largest diagonal, ties keep the lower index
      path = BrDiagX;
      if (d11 > d00) path = BrDiagY;
      if (path == BrDiagX && d22 > d00) path = BrDiagZ;
      if (path == BrDiagY && d22 > d11) path = BrDiagZ;
      case (path)
        BrDiagX: arg = d00 - (d11 + d22) + one;
        BrDiagY: arg = d11 - (d22 + d00) + one;
        default: arg = d22 - (d00 + d11) + one;
      endcase
    end
    r = '0;
    r.branch_taken = path;
    if (arg <= 0) begin
      r.invalid_input = 1'b1;
      return r;
    end
    h = root_round(longint'(arg) << (FRAC_BITS - 2));
    case (path)
      BrTrace: begin
        qw = h;
        qx = div_half_root(d21 - d12, h);
        qy = div_half_root(d02 - d20, h);
        qz = div_half_root(d10 - d01, h);
      end
      BrDiagX: begin
        qx = h;
        qy = div_half_root(d10 + d01, h);
        qz = div_half_root(d02 + d20, h);
        qw = div_half_root(d21 - d12, h);
      end
      BrDiagY: begin
        qy = h;
        qz = div_half_root(d21 + d12, h);
        qx = div_half_root(d10 + d01, h);
        qw = div_half_root(d02 - d20, h);
      end
      default: begin
        qz = h;
        qx = div_half_root(d02 + d20, h);
        qy = div_half_root(d21 + d12, h);
        qw = div_half_root(d10 - d01, h);
      end
    endcase
    r.quat_w = clamp(qw);
    r.quat_x = clamp(qx);
    r.quat_y = clamp(qy);
    r.quat_z = clamp(qz);
    return r;
  endfunction

  initial fail_count_o = 0;
  assign pending_o = quat_expected_q.size();

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      if (valid_i && ready_o) quat_expected_q.push_back(predict_quat(data_i));
      if (valid_o && ready_i) begin
        if (quat_expected_q.size() == 0) begin
          $display("%0t: unexpected beat, actual %h", $time, data_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = quat_expected_q.pop_front();
          if (want.quat_w !== data_o.quat_w || want.quat_x !== data_o.quat_x ||
              want.quat_y !== data_o.quat_y || want.quat_z !== data_o.quat_z ||
              want.branch_taken !== data_o.branch_taken ||
              want.invalid_input !== data_o.invalid_input) begin
            $display("%0t: mismatch expected w%0d x%0d y%0d z%0d br%0d inv%0b",
                     $time, want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                     want.branch_taken, want.invalid_input);
            $display("%0t:          actual   w%0d x%0d y%0d z%0d br%0d inv%0b",
                     $time, data_o.quat_w, data_o.quat_x, data_o.quat_y,
                     data_o.quat_z, data_o.branch_taken, data_o.invalid_input);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

endmodule

[test/rotation_matrix_to_quaternion_tb.sv]
// Testbench top for the rotation matrix to quaternion converter: drives
// matrices with random gaps and output stalls, gives the verdict.
// Depends on rmq_pkg, rotation_matrix_to_quaternion and its checker.
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam int unsigned Frac = 14;
  localparam int Latency = 16 + 16 + Frac + 4;
  localparam logic signed [15:0] One = 16'sd16384;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic valid_i = 1'b0;
  logic ready_i = 1'b0;
  logic ready_o, valid_o;
  in_t  data_i = '0;
  out_t data_o;
  int   fail_count, pending;
  bit   drain_mode = 1'b0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  rotation_matrix_to_quaternion #(.FRAC_BITS(Frac)) DUT (
    .clk_i, .rst_ni, .valid_i, .ready_o, .data_i, .valid_o, .ready_i, .data_o
  );

  rotation_matrix_to_quaternion_checker #(.FRAC_BITS(Frac)) u_checker (
    .clk_i, .rst_ni, .valid_i, .ready_o, .data_i, .valid_o, .ready_i, .data_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Output stalls: random waits, with a no-stall stretch in the middle
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = drain_mode ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0);
      if (stall > 0) begin
        ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      ready_i <= 1'b1;
      @(posedge clk_i);
      while (!valid_o) @(posedge clk_i);
    end
  end

  function automatic logic signed [15:0] rnd_entry();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
      default: return 16'($urandom);
    endcase
  endfunction

  // Near-rotation: permutation-like matrix with signs and small jitter
  function automatic in_t rnd_rotation();
    in_t m;
    logic signed [15:0] e [9];
    int p;
    for (int k = 0; k < 9; k++) e[k] = $signed(16'($urandom_range(0, 600))) - 16'sd300;
    p = $urandom_range(0, 5);
    for (int r = 0; r < 3; r++) begin
      int c;
      c = (p < 3) ? (r + p) % 3 : (p - r + 3) % 3;
      e[r * 3 + c] = ($urandom_range(0, 1) ? One : -One) + e[r * 3 + c];
    end
    m = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
    return m;
  endfunction

  // Valid drops only ahead of a gap, so back-to-back beats keep it high
  task automatic send_matrix(in_t m, bit gaps);
    int gap;
    gap = gaps ? (($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : 0) : 0;
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    valid_i <= 1'b1;
    data_i <= m;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    in_t m;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: identity, each diagonal path, ties, extremes
    send_matrix({One, 16'sd0, 16'sd0, 16'sd0, One, 16'sd0, 16'sd0, 16'sd0, One}, 0);
    send_matrix({One, 16'sd0, 16'sd0, 16'sd0, -One, 16'sd0, 16'sd0, 16'sd0, -One}, 0);
    send_matrix({-One, 16'sd0, 16'sd0, 16'sd0, One, 16'sd0, 16'sd0, 16'sd0, -One}, 0);
    send_matrix({-One, 16'sd0, 16'sd0, 16'sd0, -One, 16'sd0, 16'sd0, 16'sd0, One}, 0);
    send_matrix({-One, 16'sd5, 16'sd7, 16'sd9, -One, 16'sd3, 16'sd1, 16'sd2, -One}, 0);
    send_matrix({16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd1}, 0);
    send_matrix({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh8000, 16'sh8000, 16'sh8000}, 0);
    send_matrix({16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                 16'sh7fff, 16'sh7fff, 16'sh7fff}, 0);
    send_matrix({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                 16'sh8000, 16'sh7fff, 16'sh8000}, 0);
    send_matrix({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh8000,
                 16'sh7fff, 16'sh8000, 16'sh8000}, 0);
    send_matrix({16'sd0, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd0, 16'sh7fff,
                 16'sh7fff, 16'sh8000, 16'sd0}, 0);
    send_matrix({-16'sd100, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sd100, 16'sh7fff,
                 16'sh7fff, 16'sh7fff, -16'sd100}, 0);
    send_matrix({16'sd1, 16'sd2, 16'sd3, 16'sd4, 16'sh8000, 16'sd6, 16'sd7, 16'sd8, 16'sd0}, 0);
    send_matrix('1, 0);
    send_matrix('0, 0);

    // Hold off until the pipeline is empty
    wait_drained();

    // Random: mostly near-rotations, the rest arbitrary
    for (int n = 0; n < 1950; n++) begin
      if (n == 900) begin
        drain_mode = 1'b1;
        wait_drained();
      end
      if (n == 1200) drain_mode = 1'b0;
      if ($urandom_range(0, 9) < 7) begin
        m = rnd_rotation();
      end else begin
        m = {rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry(),
             rnd_entry(), rnd_entry(), rnd_entry(), rnd_entry()};
      end
      send_matrix(m, !(n >= 900 && n < 1200));
    end

    wait_drained();
    repeat (Latency + 10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("rotation_matrix_to_quaternion verification clean");
    end else begin
      $display("rotation_matrix_to_quaternion verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end

endmodule
